// File: src/scs_pkg.sv
// Shared types and result codes for the stable counting sort core.
package scs_pkg;

  // Result kind codes carried in the master-side tuser
  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_PAIR  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Request codes carried in the slave-side tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_START = 13'b0000000000010,
    S_CLEAR = 13'b0000000000100,
    S_CRD   = 13'b0000000001000,
    S_CKEY  = 13'b0000000010000,
    S_CINC  = 13'b0000000100000,
    S_PRD   = 13'b0000001000000,
    S_PADD  = 13'b0000010000000,
    S_LRD   = 13'b0000100000000,
    S_LKEY  = 13'b0001000000000,
    S_LPUT  = 13'b0010000000000,
    S_FRD   = 13'b0100000000000,
    S_FOUT  = 13'b1000000000000
  } state_t;

endpackage

// File: src/scs_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module scs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/stable_counting_sort_core.sv
// Top level of the stable counting sort core: sequencer, stores and result register.
//
// Load transactions (tuser 0) write the item to the input store; the least
// and greatest key are tracked as items arrive. A load marked by tlast, or
// the first fetch while still loading, starts the sort, which runs through
// the count memory one read-modify-write at a time, in the order set by the
// single-port access pattern of the count memory: a start step, clearing
// each key, counting each item, prefix sums over each key, placing each
// item, with a closing step after each pass. During the sort no transaction
// is accepted. Each fetch (tuser 1) then issues the memory read, registers
// the result and goes back to idle. Results come as count words (start
// position of each key from least to greatest), then the sorted pairs, then
// a repeated end marker. The count memory is cleared over the key span
// before every sort; the input and sorted stores are never cleared.
module stable_counting_sort_core
  import scs_pkg::*;
#(
  parameter int MAX_ITEMS  = 256,
  parameter int KEY_BITS   = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // item_key[7:0], item_value[23:8]
  input  logic [0:0]  s_tuser,   // mode[0]
  input  logic        s_tlast,   // final_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // start_position[8:0], sorted_key[16:9],
                                 // sorted_value[32:17], zero[39:33]
  output logic [1:0]  m_tuser,   // result_kind[1:0]
  output logic        m_tlast    // last_result
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int TW = $clog2(MAX_ITEMS + 1);
  localparam int KS = 1 << KEY_BITS;
  localparam int WW = KEY_BITS + 1;
  localparam int RW = $clog2(KS + MAX_ITEMS + 1);
  localparam int EW = KEY_BITS + VALUE_BITS;
  localparam logic [KEY_BITS-1:0] KEY_ONES = {KEY_BITS{1'b1}};

  state_t state, state_next;

  logic                draining;
  logic                pend_fetch;
  logic [TW-1:0]       item_total;
  logic [KEY_BITS-1:0] least_key;
  logic [KEY_BITS-1:0] greatest_key;
  logic [WW-1:0]       word_total;
  logic [RW-1:0]       read_pointer;
  logic [TW-1:0]       ii;
  logic [WW-1:0]       kidx;
  logic [TW-1:0]       acc;
  logic [KEY_BITS-1:0] ck;

  // Memory ports
  logic                in_we, in_re, srt_we, srt_re, cnt_we, cnt_re;
  logic [IW-1:0]       in_waddr, in_raddr, srt_waddr, srt_raddr;
  logic [KEY_BITS-1:0] cnt_waddr, cnt_raddr;
  logic [EW-1:0]       in_wdata, in_rdata, srt_rdata;
  logic [TW-1:0]       cnt_wdata, cnt_rdata;

  logic                in_acc, out_acc;
  logic [TW-1:0]       base_total;
  logic [KEY_BITS-1:0] base_least, base_greatest, key_in, rd_key;
  logic [RW-1:0]       pair_idx;
  logic                in_counts, in_pairs;

  scs_ram #(.DEPTH(MAX_ITEMS), .WIDTH(EW), .AW(IW)) u_input_store (
    .clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .re(in_re), .raddr(in_raddr), .rdata(in_rdata)
  );

  scs_ram #(.DEPTH(MAX_ITEMS), .WIDTH(EW), .AW(IW)) u_sorted_store (
    .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(in_rdata),
    .re(srt_re), .raddr(srt_raddr), .rdata(srt_rdata)
  );

  scs_ram #(.DEPTH(KS), .WIDTH(TW), .AW(KEY_BITS)) u_key_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  // Start a fresh set when loading after a sort
  assign base_total    = draining ? '0 : item_total;
  assign base_least    = draining ? KEY_ONES : least_key;
  assign base_greatest = draining ? '0 : greatest_key;
  assign key_in        = KEY_BITS'(s_tdata[7:0]);
  assign rd_key        = in_rdata[KEY_BITS-1:0] - least_key;

  // Result position decode
  assign pair_idx  = read_pointer - RW'(word_total);
  assign in_counts = read_pointer < RW'(word_total);
  assign in_pairs  = pair_idx < RW'(item_total);

  // Memory port steering
  always_comb begin
    in_we     = 1'b0;
    in_waddr  = IW'(base_total);
    in_wdata  = {VALUE_BITS'(s_tdata[23:8]), key_in};
    in_re     = 1'b0;
    in_raddr  = IW'(ii);
    srt_we    = 1'b0;
    srt_waddr = IW'(cnt_rdata - 1'b1);
    srt_re    = 1'b0;
    srt_raddr = IW'(pair_idx);
    cnt_we    = 1'b0;
    cnt_waddr = KEY_BITS'(kidx);
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = KEY_BITS'(kidx);
    unique case (state)
      S_IDLE: begin
        in_we = in_acc && (s_tuser[0] == MODE_LOAD) && (base_total < TW'(MAX_ITEMS));
      end
      S_CLEAR: begin
        cnt_we = kidx != word_total;
      end
      S_CRD: begin
        in_re = ii != item_total;
      end
      S_CKEY: begin
        cnt_re    = 1'b1;
        cnt_raddr = rd_key;
      end
      S_CINC: begin
        cnt_we    = 1'b1;
        cnt_waddr = ck;
        cnt_wdata = cnt_rdata + 1'b1;
      end
      S_PRD: begin
        cnt_re = kidx != word_total;
      end
      S_PADD: begin
        cnt_we    = 1'b1;
        cnt_wdata = acc + cnt_rdata;
      end
      S_LRD: begin
        in_re    = ii != '0;
        in_raddr = IW'(ii - 1'b1);
      end
      S_LKEY: begin
        cnt_re    = 1'b1;
        cnt_raddr = rd_key;
      end
      S_LPUT: begin
        cnt_we    = 1'b1;
        cnt_waddr = ck;
        cnt_wdata = cnt_rdata - 1'b1;
        srt_we    = 1'b1;
      end
      S_FRD: begin
        cnt_re    = in_counts;
        cnt_raddr = KEY_BITS'(read_pointer);
        srt_re    = !in_counts && in_pairs;
      end
      S_START, S_FOUT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0] == MODE_LOAD) begin
            state_next = s_tlast ? S_START : S_IDLE;
          end else begin
            state_next = draining ? S_FRD : S_START;
          end
        end
      end
      S_START: state_next = S_CLEAR;
      S_CLEAR: state_next = (kidx == word_total) ? S_CRD : S_CLEAR;
      S_CRD:   state_next = (ii == item_total) ? S_PRD : S_CKEY;
      S_CKEY:  state_next = S_CINC;
      S_CINC:  state_next = S_CRD;
      S_PRD:   state_next = (kidx == word_total) ? S_LRD : S_PADD;
      S_PADD:  state_next = S_PRD;
      S_LRD: begin
        if (ii != '0) begin
          state_next = S_LKEY;
        end else begin
          state_next = pend_fetch ? S_FRD : S_IDLE;
        end
      end
      S_LKEY:  state_next = S_LPUT;
      S_LPUT:  state_next = S_LRD;
      S_FRD:   state_next = S_FOUT;
      S_FOUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      draining     <= 1'b0;
      pend_fetch   <= 1'b0;
      item_total   <= '0;
      least_key    <= KEY_ONES;
      greatest_key <= '0;
      word_total   <= '0;
      read_pointer <= '0;
      ii           <= '0;
      kidx         <= '0;
      acc          <= '0;
      ck           <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_acc && s_tuser[0] == MODE_LOAD) begin
            draining     <= 1'b0;
            pend_fetch   <= 1'b0;
            read_pointer <= '0;
            if (base_total < TW'(MAX_ITEMS)) begin
              item_total   <= base_total + 1'b1;
              least_key    <= (key_in < base_least) ? key_in : base_least;
              greatest_key <= (key_in > base_greatest) ? key_in : base_greatest;
            end else begin
              item_total   <= base_total;
              least_key    <= base_least;
              greatest_key <= base_greatest;
            end
          end else if (in_acc) begin
            pend_fetch <= 1'b1;
          end
        end
        S_START: begin
          word_total <= (item_total != '0) ? (WW'(greatest_key) - WW'(least_key) + 1'b1)
                                           : '0;
          kidx       <= '0;
        end
        S_CLEAR: begin
          if (kidx != word_total) begin
            kidx <= kidx + 1'b1;
          end else begin
            ii   <= '0;
            kidx <= '0;
            acc  <= '0;
          end
        end
        S_CKEY: ck <= rd_key;
        S_CINC: ii <= ii + 1'b1;
        S_PRD: begin
          if (kidx == word_total) begin
            ii <= item_total;
          end
        end
        S_PADD: begin
          acc  <= acc + cnt_rdata;
          kidx <= kidx + 1'b1;
        end
        S_LRD: begin
          if (ii == '0) begin
            draining     <= 1'b1;
            read_pointer <= '0;
          end
        end
        S_LKEY: ck <= rd_key;
        S_LPUT: ii <= ii - 1'b1;
        S_FOUT: begin
          pend_fetch <= 1'b0;
          if (in_counts || in_pairs) begin
            read_pointer <= read_pointer + 1'b1;
          end
        end
        S_CRD, S_FRD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FOUT) begin
      m_tvalid <= 1'b1;
    end else if (out_acc) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state == S_FOUT) begin
      if (in_counts) begin
        m_tuser <= KIND_COUNT;
        m_tlast <= 1'b0;
        m_tdata <= {31'b0, 9'(cnt_rdata)};
      end else if (in_pairs) begin
        m_tuser <= KIND_PAIR;
        m_tlast <= (pair_idx + 1'b1) == RW'(item_total);
        m_tdata <= {7'b0, 16'(srt_rdata[EW-1:KEY_BITS]),
                    8'(srt_rdata[KEY_BITS-1:0]), 9'b0};
      end else begin
        m_tuser <= KIND_END;
        m_tlast <= 1'b1;
        m_tdata <= '0;
      end
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    item_total <= TW'(MAX_ITEMS))
    else $error("item total beyond store depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_END) |-> m_tlast)
    else $error("end marker without last flag");

  a_place_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_LPUT) |-> (cnt_rdata != '0))
    else $error("placement with an exhausted key count");

  a_fetch_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOUT) |=> m_tvalid)
    else $error("fetch finished without a result");

endmodule
